/* hw/rtl/mlqs_pkg.sv */
package mlqs_pkg;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_POP_RD,
      ST_POP_WT,
      ST_UNL_RD,
      ST_UNL_HT,
      ST_UNL_WR,
      ST_SP_RD,
      ST_SP_CMP,
      ST_START,
      ST_PUSH_RD,
      ST_PUSH_WR,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      AFT_NONE,
      AFT_PUSH,
      AFT_START
   } after_type;

   localparam logic [2:0] MODE_ADD    = 3'd0;
   localparam logic [2:0] MODE_REMOVE = 3'd1;
   localparam logic [2:0] MODE_SETPRI = 3'd2;
   localparam logic [2:0] MODE_SCHED  = 3'd3;
   localparam logic [2:0] MODE_TICK   = 3'd4;

   localparam logic REG_SLICE_LOWEST = 1'b0;
   localparam logic REG_SLICE_OTHER  = 1'b1;

   localparam logic [7:0] SLICE_LOWEST_RST = 8'd1;
   localparam logic [7:0] SLICE_OTHER_RST  = 8'd10;
   localparam logic [7:0] ELAPSED_MAX      = 8'd255;

endpackage

/* hw/rtl/mlqs_ram.sv */
module mlqs_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 6
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

/* hw/rtl/mlqs_pick.sv */
module mlqs_pick #(
   parameter int N = 32
) (
   input  logic [N-1:0]         flags,
   input  logic [N-1:0]         mask,
   output logic                 hit,
   output logic [$clog2(N)-1:0] level
);

   always_comb begin
      hit   = 1'b0;
      level = '0;
      for (int l = 0; l < N; l++) begin
         if (flags[l] && mask[l]) begin
            hit   = 1'b1;
            level = ($clog2(N))'(l);
         end
      end
   end

endmodule

/* hw/rtl/multilevel_queue_task_scheduler_top.sv */
// Multilevel queue task scheduler. Each request item adds, removes or re-prioritises a task,
// asks for a schedule or marks a tick, and yields exactly one response item with the running
// task. Run queues are doubly linked lists held in synchronous RAMs (next and previous links,
// queue heads and tails, task levels); a sequencer reads, modifies and writes them back one
// step a cycle. An item that touches no queue RAM goes from the execute state straight to the
// done state; a pop with unlink followed by requeueing the displaced task steps through pop
// read, pop wait, unlink read, unlink head/tail, unlink write, start, push read and push write.
// The next request is taken the cycle after the response is loaded, or later while the previous
// response is still waiting to be taken. After reset a clearing pass zeroes the task level
// RAM, during which no request item is taken; configuration writes are accepted throughout.
module multilevel_queue_task_scheduler_top #(
   parameter int NUM_LEVELS = 32,
   parameter int MAX_TASKS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [5:0]  req_task_id,
   input  logic [4:0]  req_priority_req,
   input  logic        req_can_preempt,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_current_task,
   output logic        rsp_current_valid,
   output logic        rsp_switched,
   output logic        rsp_found,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import mlqs_pkg::*;

   localparam int TW = $clog2(MAX_TASKS);
   localparam int LW = $clog2(NUM_LEVELS);

   state_type             state_ff, state_in;
   after_type             after_ff, after_in;
   logic [2:0]            mode_ff;
   logic [TW-1:0]         task_ff;
   logic [LW-1:0]         lvl_ff;
   logic                  may_ff;
   logic                  tok_ff;
   logic [TW-1:0]         work_ff, work_in;
   logic [LW-1:0]         pick_ff, pick_in;
   logic [TW-1:0]         rt_ff, rt_in;
   logic                  rv_ff, rv_in;
   logic [LW-1:0]         rl_ff, rl_in;
   logic [7:0]            el_ff, el_in;
   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [MAX_TASKS-1:0]  queued_ff, queued_in;
   logic [TW-1:0]         was_task_ff;
   logic                  was_valid_ff;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [5:0]            rsp_task_ff, rsp_task_in;
   logic                  rsp_cur_ff, rsp_cur_in;
   logic                  rsp_sw_ff, rsp_sw_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [TW-1:0]         clr_ff, clr_in;
   logic [7:0]            slice_lo_ff, slice_hi_ff;

   logic                  nx_we, pv_we, hd_we, tl_we, lv_we;
   logic [TW-1:0]         nx_wa, pv_wa, lv_wa;
   logic [LW-1:0]         hd_wa, tl_wa;
   logic [TW-1:0]         nx_wd, pv_wd, hd_wd, tl_wd;
   logic [LW-1:0]         lv_wd;
   logic                  tk_re, ht_re;
   logic [TW-1:0]         tk_ra;
   logic [LW-1:0]         ht_ra;
   logic [TW-1:0]         nx_q, pv_q, hd_q, tl_q;
   logic [LW-1:0]         lv_q;

   logic [NUM_LEVELS-1:0] mask_hi, mask_lo, mask_a;
   logic                  hit_a, hit_b;
   logic [LW-1:0]         lvl_a, lvl_b;
   logic [LW-1:0]         cur;
   logic [7:0]            el_new;
   logic [7:0]            slice;
   logic                  is_run, may_ok, go_pop, add_ok, sp_move;
   logic [TW-1:0]         push_task;
   logic [LW-1:0]         push_lvl;
   logic                  is_head, is_tail;
   logic                  cfg_we;
   logic                  rsp_free;

   mlqs_ram #(.DEPTH(MAX_TASKS), .WIDTH(TW)) u_next (
      .clock(clock), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
      .re(tk_re), .raddr(tk_ra), .rdata(nx_q)
   );
   mlqs_ram #(.DEPTH(MAX_TASKS), .WIDTH(TW)) u_prev (
      .clock(clock), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
      .re(tk_re), .raddr(tk_ra), .rdata(pv_q)
   );
   mlqs_ram #(.DEPTH(MAX_TASKS), .WIDTH(LW)) u_level (
      .clock(clock), .we(lv_we), .waddr(lv_wa), .wdata(lv_wd),
      .re(tk_re), .raddr(tk_ra), .rdata(lv_q)
   );
   mlqs_ram #(.DEPTH(NUM_LEVELS), .WIDTH(TW)) u_head (
      .clock(clock), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd),
      .re(ht_re), .raddr(ht_ra), .rdata(hd_q)
   );
   mlqs_ram #(.DEPTH(NUM_LEVELS), .WIDTH(TW)) u_tail (
      .clock(clock), .we(tl_we), .waddr(tl_wa), .wdata(tl_wd),
      .re(ht_re), .raddr(ht_ra), .rdata(tl_q)
   );

   mlqs_pick #(.N(NUM_LEVELS)) u_pick_a (
      .flags(nonempty_ff), .mask(mask_a), .hit(hit_a), .level(lvl_a)
   );
   mlqs_pick #(.N(NUM_LEVELS)) u_pick_b (
      .flags(nonempty_ff), .mask(mask_lo), .hit(hit_b), .level(lvl_b)
   );

   assign cur    = rv_ff ? rl_ff : '0;
   assign el_new = (rv_ff && el_ff != ELAPSED_MAX) ? el_ff + 8'd1 : el_ff;
   assign slice  = (cur == '0) ? slice_lo_ff : slice_hi_ff;
   assign is_run = rv_ff && (rt_ff == task_ff);
   assign may_ok = !rv_ff || may_ff;
   assign add_ok = tok_ff && !queued_ff[task_ff] && !is_run;
   assign sp_move = tok_ff && queued_ff[task_ff] && !is_run;
   assign go_pop = may_ok && (hit_a ||
                   (mode_ff == MODE_TICK && rv_ff && el_new >= slice && hit_b));
   assign push_task = (after_ff == AFT_START) ? rt_ff : work_ff;
   assign push_lvl  = (after_ff == AFT_START) ? rl_ff : lvl_ff;
   assign is_head = hd_q == work_ff;
   assign is_tail = tl_q == work_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         mask_hi[l] = LW'(l) > cur;
         mask_lo[l] = LW'(l) <= cur;
      end
      mask_a = (mode_ff == MODE_TICK) ? mask_hi : '1;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == TW'(MAX_TASKS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (mode_ff)
               MODE_ADD: state_in = add_ok ? ST_PUSH_RD : ST_DONE;
               MODE_REMOVE: begin
                  if (tok_ff && is_run) begin
                     state_in = hit_a ? ST_POP_RD : ST_DONE;
                  end else if (tok_ff && queued_ff[task_ff]) begin
                     state_in = ST_UNL_RD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               MODE_SETPRI: state_in = sp_move ? ST_SP_RD : ST_DONE;
               MODE_SCHED, MODE_TICK: state_in = go_pop ? ST_POP_RD : ST_DONE;
               default: state_in = ST_DONE;
            endcase
         end
         ST_POP_RD: state_in = ST_POP_WT;
         ST_POP_WT: state_in = ST_UNL_RD;
         ST_UNL_RD: state_in = ST_UNL_HT;
         ST_UNL_HT: state_in = ST_UNL_WR;
         ST_SP_RD:  state_in = ST_SP_CMP;
         ST_SP_CMP: state_in = (lv_q == lvl_ff) ? ST_DONE : ST_UNL_WR;
         ST_UNL_WR: begin
            case (after_ff)
               AFT_PUSH:  state_in = ST_PUSH_RD;
               AFT_START: state_in = ST_START;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_START:   state_in = rv_ff ? ST_PUSH_RD : ST_DONE;
         ST_PUSH_RD: state_in = ST_PUSH_WR;
         ST_PUSH_WR: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      after_in     = after_ff;
      work_in      = work_ff;
      pick_in      = pick_ff;
      rt_in        = rt_ff;
      rv_in        = rv_ff;
      rl_in        = rl_ff;
      el_in        = el_ff;
      nonempty_in  = nonempty_ff;
      queued_in    = queued_ff;
      found_in     = found_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_task_in  = rsp_task_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_found_in = rsp_found_ff;
      nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
      pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
      hd_we = 1'b0; hd_wa = '0; hd_wd = '0;
      tl_we = 1'b0; tl_wa = '0; tl_wd = '0;
      lv_we = 1'b0; lv_wa = '0; lv_wd = '0;
      tk_re = 1'b0; tk_ra = work_ff;
      ht_re = 1'b0; ht_ra = lv_q;
      case (state_ff)
         ST_CLEAR: begin
            lv_we  = 1'b1;
            lv_wa  = clr_ff;
            clr_in = clr_ff + TW'(1);
         end
         ST_IDLE: begin
            found_in = 1'b0;
         end
         ST_EXEC: begin
            work_in  = task_ff;
            after_in = AFT_NONE;
            pick_in  = hit_a ? lvl_a : lvl_b;
            case (mode_ff)
               MODE_REMOVE: begin
                  if (tok_ff && is_run) begin
                     found_in = 1'b1;
                     rv_in    = 1'b0;
                     after_in = AFT_START;
                  end else if (tok_ff && queued_ff[task_ff]) begin
                     found_in = 1'b1;
                  end
               end
               MODE_SETPRI: begin
                  after_in = AFT_PUSH;
                  if (tok_ff && !sp_move) begin
                     lv_we = 1'b1;
                     lv_wa = task_ff;
                     lv_wd = lvl_ff;
                     if (is_run) rl_in = lvl_ff;
                  end
               end
               MODE_SCHED: after_in = AFT_START;
               MODE_TICK: begin
                  after_in = AFT_START;
                  el_in    = el_new;
               end
               default: after_in = AFT_NONE;
            endcase
         end
         ST_POP_RD: begin
            ht_re = 1'b1;
            ht_ra = pick_ff;
         end
         ST_POP_WT: work_in = hd_q;
         ST_UNL_RD, ST_SP_RD: tk_re = 1'b1;
         ST_UNL_HT: ht_re = 1'b1;
         ST_SP_CMP: ht_re = lv_q != lvl_ff;
         ST_UNL_WR: begin
            queued_in[work_ff] = 1'b0;
            if (is_head && is_tail) begin
               nonempty_in[lv_q] = 1'b0;
            end else if (is_head) begin
               hd_we = 1'b1; hd_wa = lv_q; hd_wd = nx_q;
            end else if (is_tail) begin
               tl_we = 1'b1; tl_wa = lv_q; tl_wd = pv_q;
            end else begin
               nx_we = 1'b1; nx_wa = pv_q; nx_wd = nx_q;
               pv_we = 1'b1; pv_wa = nx_q; pv_wd = pv_q;
            end
         end
         ST_START: begin
            if (!rv_ff) begin
               rt_in = work_ff;
               rv_in = 1'b1;
               rl_in = pick_ff;
               el_in = '0;
            end
         end
         ST_PUSH_RD: begin
            ht_re = 1'b1;
            ht_ra = push_lvl;
         end
         ST_PUSH_WR: begin
            if (nonempty_ff[push_lvl]) begin
               nx_we = 1'b1; nx_wa = tl_q; nx_wd = push_task;
               pv_we = 1'b1; pv_wa = push_task; pv_wd = tl_q;
            end else begin
               hd_we = 1'b1; hd_wa = push_lvl; hd_wd = push_task;
               nonempty_in[push_lvl] = 1'b1;
            end
            tl_we = 1'b1; tl_wa = push_lvl; tl_wd = push_task;
            lv_we = 1'b1; lv_wa = push_task; lv_wd = push_lvl;
            queued_in[push_task] = 1'b1;
            if (after_ff == AFT_START) begin
               rt_in = work_ff;
               rv_in = 1'b1;
               rl_in = pick_ff;
               el_in = '0;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = rv_ff ? 6'(rt_ff) : 6'd0;
               rsp_cur_in   = rv_ff;
               rsp_sw_in    = (was_valid_ff != rv_ff) || (rv_ff && was_task_ff != rt_ff);
               rsp_found_in = found_ff;
            end
         end
         default: found_in = found_ff;
      endcase
   end

   assign cfg_we = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         after_ff     <= AFT_NONE;
         rv_ff        <= 1'b0;
         rt_ff        <= '0;
         rl_ff        <= '0;
         el_ff        <= '0;
         nonempty_ff  <= '0;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         slice_lo_ff  <= SLICE_LOWEST_RST;
         slice_hi_ff  <= SLICE_OTHER_RST;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         rv_ff        <= rv_in;
         rt_ff        <= rt_in;
         rl_ff        <= rl_in;
         el_ff        <= el_in;
         nonempty_ff  <= nonempty_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         if (cfg_we) begin
            case (csr_paddr[2])
               REG_SLICE_LOWEST: slice_lo_ff <= csr_pwdata[7:0];
               REG_SLICE_OTHER:  slice_hi_ff <= csr_pwdata[7:0];
               default:          slice_lo_ff <= slice_lo_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      pick_ff      <= pick_in;
      found_ff     <= found_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_cur_ff   <= rsp_cur_in;
      rsp_sw_ff    <= rsp_sw_in;
      rsp_found_ff <= rsp_found_in;
      if (state_ff == ST_IDLE && req_valid) begin
         mode_ff      <= req_mode;
         task_ff      <= TW'(req_task_id);
         tok_ff       <= 32'(req_task_id) < 32'(MAX_TASKS);
         lvl_ff       <= (32'(req_priority_req) >= 32'(NUM_LEVELS)) ?
                         LW'(NUM_LEVELS - 1) : LW'(req_priority_req);
         may_ff       <= req_can_preempt;
         was_task_ff  <= rt_ff;
         was_valid_ff <= rv_ff;
      end
   end

   assign req_ready         = state_ff == ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_task  = rsp_task_ff;
   assign rsp_current_valid = rsp_cur_ff;
   assign rsp_switched      = rsp_sw_ff;
   assign rsp_found         = rsp_found_ff;
   assign csr_pready        = 1'b1;
   assign csr_prdata        = (csr_paddr[2] == REG_SLICE_OTHER) ?
                              {24'd0, slice_hi_ff} : {24'd0, slice_lo_ff};

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import mlqs_pkg::*;

   localparam int NLEV = 32;
   localparam int NTASK = 64;
   localparam int CYCLE_LIMIT = 900000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = '0;
   logic [5:0]  req_task_id = '0;
   logic [4:0]  req_priority_req = '0;
   logic        req_can_preempt = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_current_task;
   logic        rsp_current_valid;
   logic        rsp_switched;
   logic        rsp_found;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   multilevel_queue_task_scheduler_top u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct packed {
      logic [5:0] cur_task;
      logic       cur_valid;
      logic       switched;
      logic       found;
   } sched_out_type;

   // Scheduler image.
   logic [7:0] s_lowest, s_other;
   logic [5:0] nxt [NTASK];
   logic [5:0] prv [NTASK];
   logic [5:0] qhead [NLEV];
   logic [5:0] qtail [NLEV];
   logic       qfull [NLEV];
   logic [4:0] lvl_of [NTASK];
   logic       queued [NTASK];
   logic [5:0] run_id;
   logic       run_on;
   logic [7:0] elapsed;

   sched_out_type pending[$];
   int errors = 0;
   int cycles = 0;
   int n_results = 0;
   int n_switches = 0;

   function automatic void img_reset();
      s_lowest = SLICE_LOWEST_RST;
      s_other = SLICE_OTHER_RST;
      for (int i = 0; i < NTASK; i++) begin
         nxt[i] = '0; prv[i] = '0; lvl_of[i] = '0; queued[i] = 1'b0;
      end
      for (int i = 0; i < NLEV; i++) begin
         qhead[i] = '0; qtail[i] = '0; qfull[i] = 1'b0;
      end
      run_id = '0; run_on = 1'b0; elapsed = '0;
   endfunction

   function automatic void enqueue(logic [4:0] l, logic [5:0] t);
      if (qfull[l]) begin
         nxt[qtail[l]] = t;
         prv[t] = qtail[l];
      end else begin
         qhead[l] = t;
         qfull[l] = 1'b1;
      end
      qtail[l] = t;
      lvl_of[t] = l;
      queued[t] = 1'b1;
   endfunction

   function automatic void dequeue(logic [5:0] t);
      logic [4:0] l;
      logic hd, tl;
      l = lvl_of[t];
      hd = qhead[l] == t;
      tl = qtail[l] == t;
      if (hd && tl) qfull[l] = 1'b0;
      else if (hd) qhead[l] = nxt[t];
      else if (tl) qtail[l] = prv[t];
      else begin
         nxt[prv[t]] = nxt[t];
         prv[nxt[t]] = prv[t];
      end
      queued[t] = 1'b0;
   endfunction

   function automatic int take_highest(int top, int bottom);
      logic [5:0] t;
      for (int l = top; l >= bottom; l--) begin
         if (qfull[l]) begin
            t = qhead[l];
            dequeue(t);
            return int'(t);
         end
      end
      return -1;
   endfunction

   function automatic void dispatch(int t);
      if (t < 0) return;
      if (run_on) enqueue(lvl_of[run_id], run_id);
      run_id = t[5:0];
      run_on = 1'b1;
      elapsed = '0;
   endfunction

   function automatic sched_out_type predict_schedule(logic [2:0] m, logic [5:0] t,
                                                      logic [4:0] l, logic may);
      sched_out_type r;
      logic [5:0] was_id;
      logic was_on, fnd;
      int cur, pick;
      was_id = run_id;
      was_on = run_on;
      fnd = 1'b0;
      case (m)
         MODE_ADD: begin
            if (!queued[t] && !(run_on && run_id == t)) enqueue(l, t);
         end
         MODE_REMOVE: begin
            if (run_on && run_id == t) begin
               fnd = 1'b1;
               run_on = 1'b0;
               dispatch(take_highest(NLEV - 1, 0));
            end else if (queued[t]) begin
               fnd = 1'b1;
               dequeue(t);
            end
         end
         MODE_SETPRI: begin
            if (queued[t] && !(run_on && run_id == t)) begin
               if (lvl_of[t] != l) begin
                  dequeue(t);
                  enqueue(l, t);
               end
            end else lvl_of[t] = l;
         end
         MODE_SCHED: begin
            if (!run_on || may) dispatch(take_highest(NLEV - 1, 0));
         end
         MODE_TICK: begin
            if (run_on && elapsed < ELAPSED_MAX) elapsed++;
            if (!run_on || may) begin
               cur = run_on ? int'(lvl_of[run_id]) : 0;
               pick = take_highest(NLEV - 1, cur + 1);
               if (pick < 0 && run_on) begin
                  if (elapsed >= ((cur == 0) ? s_lowest : s_other))
                     pick = take_highest(cur, 0);
               end
               dispatch(pick);
            end
         end
         default: ;
      endcase
      r.cur_task = run_on ? run_id : '0;
      r.cur_valid = run_on;
      r.switched = (was_on != run_on) || (run_on && was_id != run_id);
      r.found = fnd;
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver stall pattern.
   int stall_mode = 0;
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ((cycles % 7) < 3);
      endcase
   end

   always @(posedge clock) begin
      sched_out_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            e = pending[0];
            pending.delete(0);
            n_results++;
            if (rsp_switched) n_switches++;
            if (rsp_current_task !== e.cur_task) begin
               $error("current_task exp %0d got %0d", e.cur_task, rsp_current_task);
               errors++;
            end
            if (rsp_current_valid !== e.cur_valid) begin
               $error("current_valid exp %0d got %0d", e.cur_valid, rsp_current_valid);
               errors++;
            end
            if (rsp_switched !== e.switched) begin
               $error("switched exp %0d got %0d", e.switched, rsp_switched);
               errors++;
            end
            if (rsp_found !== e.found) begin
               $error("found exp %0d got %0d", e.found, rsp_found);
               errors++;
            end
         end
      end
   end

   int burst_left = 0;

   task automatic send_item(logic [2:0] m, logic [5:0] t, logic [4:0] l, logic may);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mode <= m;
      req_task_id <= t;
      req_priority_req <= l;
      req_can_preempt <= may;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending.insert(pending.size(), predict_schedule(m, t, l, may));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] val);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (idx == REG_SLICE_LOWEST) s_lowest = val[7:0];
      else s_other = val[7:0];
   endtask

   task automatic set_slices(logic [7:0] lo, logic [7:0] hi);
      drain();
      csr_write(REG_SLICE_LOWEST, {24'd0, lo});
      csr_write(REG_SLICE_OTHER, {24'd0, hi});
   endtask

   task automatic test_directed();
      send_item(MODE_TICK, 6'd0, 5'd0, 1'b1);
      send_item(MODE_REMOVE, 6'd63, 5'd0, 1'b0);
      send_item(MODE_ADD, 6'd0, 5'd0, 1'b0);
      send_item(MODE_ADD, 6'd63, 5'd31, 1'b0);
      send_item(MODE_ADD, 6'd63, 5'd3, 1'b0);
      send_item(MODE_TICK, 6'd0, 5'd0, 1'b0);
      send_item(MODE_ADD, 6'd5, 5'd31, 1'b0);
      send_item(MODE_SCHED, 6'd0, 5'd0, 1'b0);
      send_item(MODE_SCHED, 6'd0, 5'd0, 1'b1);
      send_item(MODE_SETPRI, 6'd5, 5'd0, 1'b0);
      send_item(MODE_SETPRI, 6'd9, 5'd7, 1'b0);
      send_item(MODE_ADD, 6'd9, 5'd20, 1'b0);
      send_item(MODE_TICK, 6'd0, 5'd0, 1'b1);
      send_item(3'd5, 6'd0, 5'd0, 1'b1);
      send_item(3'd7, 6'd63, 5'd31, 1'b1);
      send_item(MODE_REMOVE, 6'd9, 5'd0, 1'b0);
      send_item(MODE_SCHED, 6'd0, 5'd0, 1'b1);
      send_item(MODE_TICK, 6'd0, 5'd0, 1'b1);
      send_item(MODE_REMOVE, 6'd0, 5'd0, 1'b0);
      send_item(MODE_REMOVE, 6'd63, 5'd0, 1'b1);
      send_item(MODE_TICK, 6'd0, 5'd0, 1'b1);
   endtask

   task automatic test_random(int n);
      int k;
      logic [2:0] m;
      k = $urandom_range(0, 99);
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 25) m = MODE_ADD;
         else if (k < 37) m = MODE_REMOVE;
         else if (k < 47) m = MODE_SETPRI;
         else if (k < 57) m = MODE_SCHED;
         else if (k < 97) m = MODE_TICK;
         else m = 3'($urandom_range(5, 7));
         send_item(m, 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)),
                   1'($urandom_range(0, 3) != 0));
      end
   endtask

   initial begin
      img_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      set_slices(8'd255, 8'd1);
      stall_mode = 1;
      test_random(350);
      drain();
      set_slices(8'd2, 8'd3);
      stall_mode = 2;
      test_random(350);
      set_slices(8'd1, 8'd255);
      stall_mode = 0;
      test_random(350);
      set_slices(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
      stall_mode = 1;
      test_random(350);
      drain();
      $display("Covered %0d results (%0d task switches) over four slice settings.",
               n_results, n_switches);
      if (errors == 0 && pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
